// ===== rtl/core/pnr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnr_pkg
// Shared types, character codes and byte classes of the phone number
// recogniser.
// ----------------------------------------------------------------------------
package pnr_pkg;

   // character codes
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_HYPHEN     = 8'h2D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_HIGH       = 8'h80;

   // date shape dddd-dd-dd
   localparam logic [6:0] DATE_LEN      = 7'd10;
   localparam logic [6:0] DATE_HYPHEN_A = 7'd4;
   localparam logic [6:0] DATE_HYPHEN_B = 7'd7;
   localparam logic [6:0] LEN_MAX       = 7'd127;

   // register reset values
   localparam logic [4:0] MIN_DIGITS_RST = 5'd7;
   localparam logic [4:0] MAX_DIGITS_RST = 5'd15;
   localparam logic [2:0] AREA_MIN_RST   = 3'd2;
   localparam logic [2:0] AREA_MAX_RST   = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_MIN_DIGITS = 2'd0;
   localparam logic [1:0] CSR_MAX_DIGITS = 2'd1;
   localparam logic [1:0] CSR_AREA_MIN   = 2'd2;
   localparam logic [1:0] CSR_AREA_MAX   = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PLUS  = 3'd1,
      PH_AREA  = 3'd2,
      PH_CLOSE = 3'd3,
      PH_MAIN  = 3'd4,
      PH_SEP   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       has_previous;
      logic [7:0] previous_byte;
   } req_item_type;

   typedef struct packed {
      logic       matched;
      logic [6:0] match_length;
   } rsp_type;

   typedef struct packed {
      logic [4:0] min_digits;
      logic [4:0] max_digits;
      logic [2:0] area_min;
      logic [2:0] area_max;
   } cfg_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c inside {CH_SPACE, CH_HYPHEN};
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z],
                       [CH_ZERO:CH_NINE], CH_UNDERSCORE} || c >= CH_HIGH;
   endfunction

endpackage

// ===== rtl/core/pnr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnr_core
// Per-byte scanner: candidate state registers and the single-step decision
// that yields at most one verdict per beat.
// ----------------------------------------------------------------------------
module pnr_core import pnr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   input  cfg_type      cfg,
   output logic         res_valid,
   output rsp_type      res
);

   typedef enum logic [1:0] {
      VD_NONE   = 2'd0,
      VD_FAIL   = 2'd1,
      VD_FINISH = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      LS_CUR   = 2'd0,
      LS_TAKEN = 2'd1,
      LS_BACK  = 2'd2
   } len_sel_type;

   typedef struct packed {
      logic        take;
      logic        inc_digit;
      logic        inc_area;
      phase_type   phase;
      verdict_type verdict;
      len_sel_type len_sel;
      logic        right_chk;
   } decision_type;

   phase_type    phase_ff, phase_in;
   logic [4:0]   digits_ff, digits_in;
   logic [6:0]   length_ff, length_in;
   logic [2:0]   area_ff, area_in;
   logic         date_ok_ff, date_ok_in;
   logic         left_ok_ff, left_ok_in;

   logic [7:0]   c;
   logic         dig, sep;
   logic [4:0]   digits_cur, digits_new;
   logic [6:0]   length_cur, len_taken, len_fin;
   logic [2:0]   area_cur, area_new;
   logic         date_cur, date_new, date_hit, left_cur;
   logic         ok;
   decision_type mb, dec;

   assign c   = item.data_byte;
   assign dig = is_digit(c);
   assign sep = is_sep(c);

   // a start byte sees a fresh candidate
   assign digits_cur = item.first_byte ? 5'd0 : digits_ff;
   assign length_cur = item.first_byte ? 7'd0 : length_ff;
   assign area_cur   = item.first_byte ? 3'd0 : area_ff;
   assign date_cur   = item.first_byte ? 1'b1 : date_ok_ff;
   assign left_cur   = item.first_byte ?
                       !(item.has_previous && is_ident(item.previous_byte)) : left_ok_ff;

   // main digit / separator step
   always_comb begin
      mb.take      = 1'b0;
      mb.inc_digit = 1'b0;
      mb.inc_area  = 1'b0;
      mb.phase     = PH_IDLE;
      mb.verdict   = VD_FINISH;
      mb.len_sel   = LS_CUR;
      mb.right_chk = 1'b1;
      if (dig) begin
         if (digits_cur >= cfg.max_digits) begin
            mb.verdict = VD_FAIL;
         end else begin
            mb.take      = 1'b1;
            mb.inc_digit = 1'b1;
            mb.phase     = PH_MAIN;
            mb.verdict   = item.last_byte ? VD_FINISH : VD_NONE;
            mb.len_sel   = LS_TAKEN;
            mb.right_chk = 1'b0;
         end
      end else if (sep && length_cur != 7'd0 && !item.last_byte) begin
         mb.take    = 1'b1;
         mb.phase   = PH_SEP;
         mb.verdict = VD_NONE;
      end
   end

   // decision for this beat
   always_comb begin
      dec.take      = 1'b0;
      dec.inc_digit = 1'b0;
      dec.inc_area  = 1'b0;
      dec.phase     = phase_ff;
      dec.verdict   = VD_NONE;
      dec.len_sel   = LS_CUR;
      dec.right_chk = 1'b0;
      if (item.first_byte) begin
         if (c == CH_PLUS) begin
            dec.take    = 1'b1;
            dec.phase   = PH_PLUS;
            dec.verdict = item.last_byte ? VD_FAIL : VD_NONE;
         end else if (c == CH_LPAREN) begin
            dec.take    = 1'b1;
            dec.phase   = PH_AREA;
            dec.verdict = item.last_byte ? VD_FAIL : VD_NONE;
         end else begin
            dec = mb;
         end
      end else begin
         case (phase_ff)
            PH_PLUS: begin
               if (dig) begin
                  dec = mb;
               end else begin
                  dec.verdict = VD_FAIL;
               end
            end
            PH_AREA: begin
               if (dig && area_cur < cfg.area_max) begin
                  dec.take      = 1'b1;
                  dec.inc_digit = 1'b1;
                  dec.inc_area  = 1'b1;
                  dec.verdict   = item.last_byte ? VD_FAIL : VD_NONE;
               end else if (c == CH_RPAREN && area_cur >= cfg.area_min) begin
                  dec.take    = 1'b1;
                  dec.phase   = PH_CLOSE;
                  dec.verdict = item.last_byte ? VD_FINISH : VD_NONE;
                  dec.len_sel = LS_TAKEN;
               end else begin
                  dec.verdict = VD_FAIL;
               end
            end
            PH_CLOSE: begin
               if (sep) begin
                  dec.take    = 1'b1;
                  dec.phase   = PH_MAIN;
                  dec.verdict = item.last_byte ? VD_FINISH : VD_NONE;
                  dec.len_sel = LS_TAKEN;
               end else begin
                  dec = mb;
               end
            end
            PH_MAIN: begin
               dec = mb;
            end
            PH_SEP: begin
               if (dig) begin
                  dec = mb;
               end else begin
                  // the trailing separator is the right neighbour
                  dec.verdict = VD_FINISH;
                  dec.len_sel = LS_BACK;
               end
            end
            default: begin
               dec.phase = PH_IDLE;
            end
         endcase
      end
   end

   // counter and shape updates
   assign len_taken  = (length_cur == LEN_MAX) ? length_cur : length_cur + 7'd1;
   assign date_hit   = (length_cur == DATE_HYPHEN_A || length_cur == DATE_HYPHEN_B) ?
                       (c == CH_HYPHEN) : dig;
   assign date_new   = date_cur & ~(dec.take & (length_cur < DATE_LEN) & ~date_hit);
   assign digits_new = digits_cur + {4'd0, dec.inc_digit};
   assign area_new   = area_cur + {2'd0, dec.inc_area};

   // next state
   always_comb begin
      phase_in   = phase_ff;
      digits_in  = digits_ff;
      length_in  = length_ff;
      area_in    = area_ff;
      date_ok_in = date_ok_ff;
      left_ok_in = left_ok_ff;
      if (item_valid) begin
         phase_in   = (dec.verdict != VD_NONE) ? PH_IDLE : dec.phase;
         digits_in  = digits_new;
         length_in  = dec.take ? len_taken : length_cur;
         area_in    = area_new;
         date_ok_in = date_new;
         left_ok_in = left_cur;
      end
   end

   // verdict
   always_comb begin
      case (dec.len_sel)
         LS_TAKEN: len_fin = len_taken;
         LS_BACK:  len_fin = length_cur - 7'd1;
         default:  len_fin = length_cur;
      endcase
      ok = (dec.verdict == VD_FINISH) &&
           digits_new >= cfg.min_digits && digits_new <= cfg.max_digits &&
           len_fin != 7'd0 && left_cur &&
           !(dec.right_chk && is_ident(c)) &&
           !(len_fin == DATE_LEN && date_new);
      res_valid        = item_valid && (dec.verdict != VD_NONE);
      res.matched      = ok;
      res.match_length = ok ? len_fin : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         digits_ff  <= 5'd0;
         length_ff  <= 7'd0;
         area_ff    <= 3'd0;
         date_ok_ff <= 1'b1;
         left_ok_ff <= 1'b1;
      end else begin
         phase_ff   <= phase_in;
         digits_ff  <= digits_in;
         length_ff  <= length_in;
         area_ff    <= area_in;
         date_ok_ff <= date_ok_in;
         left_ok_ff <= left_ok_in;
      end
   end

endmodule

// ===== rtl/core/pnr_rsp_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnr_rsp_skid
// Result output register with a skid entry, so the scanner can hand over
// one more verdict after the receiver stalls.
// ----------------------------------------------------------------------------
module pnr_rsp_skid import pnr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_ready
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop        = out_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== rtl/core/phone_number_recognizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phone_number_recognizer
// Streams text bytes and reports whether a phone number starts at each
// candidate offset marked by req_first_byte.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one text byte per beat (valid/ready). A beat with
//   req_first_byte opens a candidate; on that beat req_has_previous and
//   req_previous_byte give the byte before it. Bytes outside a candidate
//   are taken and dropped.
//   rsp_* carries one verdict per candidate: rsp_matched and
//   rsp_match_length (0 when not matched).
//   csr_wr_en writes csr_wr_data into register csr_index (min_digits, max_digits,
//   area_min, area_max); the user must write only with no candidate pending (unenforced).
// Timing
//   One byte per cycle sustained while the receiver keeps up. The beat that
//   settles a verdict passes the input register and then the scan step into
//   the output register, where rsp_valid rises; a full skid entry holds it
//   in the input register until the receiver takes a verdict.
//   Reset empties both registers, returns the scanner to waiting for a
//   start and loads the register defaults 7, 15, 2 and 4.
//   When the receiver stalls, one more verdict lands in the skid entry;
//   after that the scanner holds, and req_ready drops once the input
//   register is occupied, until the receiver takes a beat.
// ----------------------------------------------------------------------------
module phone_number_recognizer import pnr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       req_has_previous,
   input  logic [7:0] req_previous_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic [6:0] rsp_match_length,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_wr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   logic         req_fire, core_go, push_ready;
   logic         core_res_valid;
   rsp_type      core_res, rsp_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_DIGITS: cfg_in.min_digits = csr_wr_data;
            CSR_MAX_DIGITS: cfg_in.max_digits = csr_wr_data;
            CSR_AREA_MIN:   cfg_in.area_min   = csr_wr_data[2:0];
            CSR_AREA_MAX:   cfg_in.area_max   = csr_wr_data[2:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // input register
   assign req_fire  = req_valid && req_ready;
   assign core_go   = s1_valid_ff && push_ready;
   assign req_ready = !s1_valid_ff || push_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_valid_in              = 1'b1;
         s1_item_in.data_byte     = req_data_byte;
         s1_item_in.first_byte    = req_first_byte;
         s1_item_in.last_byte     = req_last_byte;
         s1_item_in.has_previous  = req_has_previous;
         s1_item_in.previous_byte = req_previous_byte;
      end else if (core_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         cfg_ff.min_digits <= MIN_DIGITS_RST;
         cfg_ff.max_digits <= MAX_DIGITS_RST;
         cfg_ff.area_min   <= AREA_MIN_RST;
         cfg_ff.area_max   <= AREA_MAX_RST;
      end else begin
         s1_valid_ff <= s1_valid_in;
         cfg_ff      <= cfg_in;
      end
      s1_item_ff <= s1_item_in;
   end

   pnr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (core_go),
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .res_valid  (core_res_valid),
      .res        (core_res)
   );

   pnr_rsp_skid u_rsp_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (core_res_valid),
      .push_data  (core_res),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_ready  (rsp_ready)
   );

   assign rsp_matched      = rsp_data.matched;
   assign rsp_match_length = rsp_data.match_length;

   // a failed verdict never carries a length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_match_length == 7'd0)
      else $error("unmatched verdict with nonzero length");

   // a matched verdict always spans at least one byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_match_length != 7'd0)
      else $error("matched verdict with zero length");

   // the skid entry only fills behind an occupied output register
   assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> rsp_valid)
      else $error("skid entry full while output empty");

   // a held input beat is not lost while the result path is full
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !push_ready |=> s1_valid_ff)
      else $error("input beat dropped under back-pressure");

endmodule

// ===== verif/tb_phone_number_recognizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phone_number_recognizer
// Streams text bytes into the recogniser under random back-pressure and
// compares every verdict with a cycle-free scanner model. A short directed
// run covers dates, area codes and plus signs. Random runs follow, each
// under its own register setting.
// ----------------------------------------------------------------------------
module tb_phone_number_recognizer;
   import pnr_pkg::*;

   localparam int IDLE_PCT    = 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE      = 6;
   localparam int PHASE_BEATS = 68;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_now = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b1;
   logic         rsp_matched;
   logic [6:0]   rsp_match_length;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = CSR_MIN_DIGITS;
   logic [4:0]   csr_wr_data = '0;

   req_item_type text_q[$];
   rsp_type      verdict_q[$];
   logic [7:0]   draft[$];
   int unsigned  queued_count = 0;
   int unsigned  accepted_count = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  mismatch_count = 0;
   bit           req_taken = 1'b0;
   bit           steady = 1'b0;

   // scanner model state
   cfg_type      cfg = '{MIN_DIGITS_RST, MAX_DIGITS_RST, AREA_MIN_RST, AREA_MAX_RST};
   phase_type    scan_phase = PH_IDLE;
   int unsigned  digit_tally = 0;
   int unsigned  span_len = 0;
   int unsigned  area_tally = 0;
   bit           date_like = 1'b1;
   bit           left_ok = 1'b1;
   bit           verdict_done = 1'b1;

   phone_number_recognizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_now.data_byte),
      .req_first_byte    (req_now.first_byte),
      .req_last_byte     (req_now.last_byte),
      .req_has_previous  (req_now.has_previous),
      .req_previous_byte (req_now.previous_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_match_length  (rsp_match_length),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic bit digit_char(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit sep_char(input logic [7:0] c);
      return c == CH_SPACE || c == CH_HYPHEN;
   endfunction

   function automatic bit word_char(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             digit_char(c) || c == CH_UNDERSCORE || c >= CH_HIGH;
   endfunction

   // extend the match by one byte, tracking whether it still looks like a date
   function automatic void grow_span(input logic [7:0] c);
      if (span_len < DATE_LEN) begin
         if (span_len == DATE_HYPHEN_A || span_len == DATE_HYPHEN_B) begin
            if (c != CH_HYPHEN) date_like = 1'b0;
         end else if (!digit_char(c)) begin
            date_like = 1'b0;
         end
      end
      if (span_len < LEN_MAX) span_len++;
   endfunction

   function automatic void give_verdict(input bit ok, input int unsigned len);
      rsp_type v;
      v.matched = ok;
      v.match_length = ok ? 7'(len) : 7'd0;
      verdict_q.push_back(v);
      scan_phase = PH_IDLE;
      verdict_done = 1'b1;
   endfunction

   function automatic void judge(input bit has_next, input logic [7:0] nxt,
                                 input int unsigned len);
      bit ok;
      ok = digit_tally >= cfg.min_digits && digit_tally <= cfg.max_digits && len > 0 &&
           left_ok && !(has_next && word_char(nxt)) && !(len == DATE_LEN && date_like);
      give_verdict(ok, len);
   endfunction

   function automatic void main_part(input logic [7:0] c, input bit last);
      if (digit_char(c)) begin
         if (digit_tally >= cfg.max_digits) begin
            give_verdict(1'b0, 0);
         end else begin
            digit_tally++;
            grow_span(c);
            scan_phase = PH_MAIN;
            if (last) judge(1'b0, 8'h00, span_len);
         end
      end else if (sep_char(c)) begin
         if (span_len == 0 || last) begin
            judge(1'b1, c, span_len);
         end else begin
            grow_span(c);
            scan_phase = PH_SEP;
         end
      end else begin
         judge(1'b1, c, span_len);
      end
   endfunction

   function automatic void scan_byte(input req_item_type it);
      logic [7:0] c;
      c = it.data_byte;
      if (it.first_byte) begin
         digit_tally = 0;
         span_len = 0;
         area_tally = 0;
         date_like = 1'b1;
         left_ok = !(it.has_previous && word_char(it.previous_byte));
         verdict_done = 1'b0;
         if (c == CH_PLUS || c == CH_LPAREN) begin
            grow_span(c);
            if (c == CH_PLUS) scan_phase = PH_PLUS;
            else scan_phase = PH_AREA;
            if (it.last_byte) give_verdict(1'b0, 0);
         end else begin
            main_part(c, it.last_byte);
         end
      end else if (!verdict_done && scan_phase != PH_IDLE) begin
         case (scan_phase)
            PH_PLUS: begin
               if (!digit_char(c)) give_verdict(1'b0, 0);
               else main_part(c, it.last_byte);
            end
            PH_AREA: begin
               if (digit_char(c) && area_tally < cfg.area_max) begin
                  grow_span(c);
                  area_tally++;
                  digit_tally++;
                  if (it.last_byte) give_verdict(1'b0, 0);
               end else if (c == CH_RPAREN && area_tally >= cfg.area_min) begin
                  grow_span(c);
                  scan_phase = PH_CLOSE;
                  if (it.last_byte) judge(1'b0, 8'h00, span_len);
               end else begin
                  give_verdict(1'b0, 0);
               end
            end
            PH_CLOSE: begin
               if (sep_char(c)) begin
                  grow_span(c);
                  scan_phase = PH_MAIN;
                  if (it.last_byte) judge(1'b0, 8'h00, span_len);
               end else begin
                  main_part(c, it.last_byte);
               end
            end
            PH_MAIN: main_part(c, it.last_byte);
            PH_SEP: begin
               // a separator not followed by a digit is the right neighbour
               if (digit_char(c)) main_part(c, it.last_byte);
               else judge(1'b0, 8'h00, span_len - 1);
            end
            default: begin
               scan_phase = PH_IDLE;
               verdict_done = 1'b1;
            end
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] any_text_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return CH_ZERO + 8'($urandom_range(0, 9));
      if (r < 45) return CH_SPACE;
      if (r < 55) return CH_HYPHEN;
      if (r < 60) return CH_PLUS;
      if (r < 65) return CH_LPAREN;
      if (r < 70) return CH_RPAREN;
      if (r < 78) return CH_LOWER_A + 8'($urandom_range(0, 25));
      if (r < 82) return CH_UPPER_A + 8'($urandom_range(0, 25));
      if (r < 85) return CH_UNDERSCORE;
      if (r < 90) return CH_HIGH + 8'($urandom_range(0, 127));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] any_sep();
      return $urandom_range(0, 1) ? CH_SPACE : CH_HYPHEN;
   endfunction

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
   endtask

   task automatic add_digits(input int unsigned n);
      repeat (n) draft.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // move the drafted text into the send queue as one candidate
   task automatic send_draft(input bit hp, input logic [7:0] prev, input bit close);
      req_item_type it;
      for (int i = 0; i < draft.size(); i++) begin
         it.data_byte = draft[i];
         it.first_byte = (i == 0);
         it.last_byte = close && (i == draft.size() - 1);
         it.has_previous = (i == 0) ? hp : 1'($urandom_range(0, 1));
         it.previous_byte = (i == 0) ? prev : 8'($urandom_range(0, 255));
         text_q.push_back(it);
         queued_count++;
      end
      draft.delete();
   endtask

   // a byte outside any candidate, or one that ends the text
   task automatic send_loose(input logic [7:0] c, input bit close);
      req_item_type it;
      it.data_byte = c;
      it.first_byte = 1'b0;
      it.last_byte = close;
      it.has_previous = 1'($urandom_range(0, 1));
      it.previous_byte = 8'($urandom_range(0, 255));
      text_q.push_back(it);
      queued_count++;
   endtask

   function automatic int unsigned digit_total();
      int unsigned n;
      case ($urandom_range(0, 3))
         0: n = cfg.min_digits;
         1: n = cfg.max_digits;
         2: n = int'(cfg.max_digits) + 1;
         default: n = $urandom_range(1, 16);
      endcase
      return (n == 0) ? 1 : n;
   endfunction

   task automatic add_random_candidate();
      int unsigned shape;
      int unsigned total;
      int unsigned grp;
      int unsigned area_n;
      bit close;
      shape = $urandom_range(0, 19);
      close = ($urandom_range(0, 7) == 0);
      if (shape < 14) begin
         if ($urandom_range(0, 3) == 0) draft.push_back(CH_PLUS);
         total = digit_total();
         if ($urandom_range(0, 2) == 0) begin
            area_n = $urandom_range(0, int'(cfg.area_max) + 1);
            draft.push_back(CH_LPAREN);
            add_digits(area_n);
            draft.push_back(CH_RPAREN);
            if ($urandom_range(0, 1)) draft.push_back(any_sep());
            total = (total > area_n) ? total - area_n : 1;
         end
         while (total > 0) begin
            grp = $urandom_range(1, 5);
            if (grp > total) grp = total;
            add_digits(grp);
            total -= grp;
            if (total > 0 && $urandom_range(0, 2) == 0) begin
               draft.push_back(any_sep());
               // doubled separator breaks the number
               if ($urandom_range(0, 19) == 0) draft.push_back(any_sep());
            end
         end
         if ($urandom_range(0, 5) == 0) draft.push_back(any_sep());
      end else if (shape < 16) begin
         add_digits(4);
         draft.push_back($urandom_range(0, 4) ? CH_HYPHEN : any_text_byte());
         add_digits(2);
         draft.push_back(CH_HYPHEN);
         add_digits(2);
      end else begin
         repeat ($urandom_range(1, 8)) draft.push_back(any_text_byte());
      end
      if (!close) draft.push_back(any_text_byte());
      send_draft($urandom_range(0, 3) != 0, any_text_byte(), close);
      // stray bytes between candidates
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) send_loose(any_text_byte(), 1'b0);
      end
   endtask

   // hold until every byte is taken and every verdict is back
   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || verdict_q.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [4:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
   endtask

   task automatic load_setting(input logic [4:0] mn, input logic [4:0] mx,
                               input logic [2:0] amn, input logic [2:0] amx);
      csr_write(CSR_MIN_DIGITS, mn);
      csr_write(CSR_MAX_DIGITS, mx);
      csr_write(CSR_AREA_MIN, 5'(amn));
      csr_write(CSR_AREA_MAX, 5'(amx));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg.min_digits = mn;
      cfg.max_digits = mx;
      cfg.area_min = amn;
      cfg.area_max = amx;
   endtask

   task automatic run_phase(input logic [4:0] mn, input logic [4:0] mx,
                            input logic [2:0] amn, input logic [2:0] amx, input bit calm);
      int unsigned goal;
      wait_idle();
      load_setting(mn, mx, amn, amx);
      @(posedge clock);
      steady = calm;
      goal = queued_count + PHASE_BEATS;
      while (queued_count < goal) add_random_candidate();
      // close any open candidate so the next setting starts clean
      send_loose(any_text_byte(), 1'b1);
   endtask

   // ------------------------------------------------------------------------
   // sender, receiver and checker
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (text_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_now <= text_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= reset || steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            scan_byte(req_now);
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict beat with none expected: matched %0d, match_length %0d",
                      rsp_matched, rsp_match_length);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_matched !== want.matched) begin
                  $error("matched: expected %0d, actual %0d", want.matched, rsp_matched);
                  mismatch_count++;
               end
               if (rsp_match_length !== want.match_length) begin
                  $error("match_length: expected %0d, actual %0d",
                         want.match_length, rsp_match_length);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [4:0] mn;
      logic [4:0] mx;
      logic [2:0] amn;
      logic [2:0] amx;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, register defaults
      send_loose(8'h00, 1'b0);
      add_str("1234-56-78.");
      send_draft(1'b0, 8'hFF, 1'b0);
      add_str("(12) 3456-7");
      send_draft(1'b1, CH_SPACE, 1'b1);
      add_str("+a");
      send_draft(1'b1, CH_LOWER_Z, 1'b0);
      draft.push_back(8'hFF);
      send_draft(1'b1, 8'h00, 1'b0);

      run_phase(5'd1, 5'd31, 3'd1, 3'd7, 1'b1);
      run_phase(5'd31, 5'd31, 3'd7, 3'd7, 1'b0);
      // fewest above most, empty parentheses allowed
      run_phase(5'd12, 5'd5, 3'd0, 3'd1, 1'b0);
      // no digit allowed at all
      run_phase(5'd1, 5'd0, 3'd3, 3'd2, 1'b0);
      repeat (2) begin
         mn = 5'($urandom_range(1, 31));
         mx = 5'($urandom_range(mn, 31));
         amn = 3'($urandom_range(1, 7));
         amx = 3'($urandom_range(amn, 7));
         run_phase(mn, mx, amn, amx, 1'b0);
      end
      run_phase(MIN_DIGITS_RST, MAX_DIGITS_RST, AREA_MIN_RST, AREA_MAX_RST, 1'b0);

      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
